// ----- rtl/hred_pkg.sv -----
// Package for the HTTP request end detector: scan codes, status codes,
// the result word type and the scan transition function.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hred_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned ByteWidth  = 8;

  localparam logic [CountWidth-1:0] CapacityReset = 16'd2048;

  localparam logic [3:0] ScanFirstWord  = 4'd0;
  localparam logic [3:0] ScanGap1       = 4'd1;
  localparam logic [3:0] ScanSecondWord = 4'd2;
  localparam logic [3:0] ScanGap2       = 4'd3;
  localparam logic [3:0] ScanHeaderText = 4'd4;
  localparam logic [3:0] ScanTextCr     = 4'd5;
  localparam logic [3:0] ScanLineStart  = 4'd6;
  localparam logic [3:0] ScanLineCr     = 4'd7;
  localparam logic [3:0] ScanDone       = 4'd8;
  localparam logic [3:0] ScanBad        = 4'd9;

  localparam logic [1:0] StatIncomplete = 2'd0;
  localparam logic [1:0] StatComplete   = 2'd1;
  localparam logic [1:0] StatMalformed  = 2'd2;
  localparam logic [1:0] StatOverflow   = 2'd3;

  localparam logic [ByteWidth-1:0] ChSpace = 8'h20;
  localparam logic [ByteWidth-1:0] ChTab   = 8'h09;
  localparam logic [ByteWidth-1:0] ChCr    = 8'h0D;
  localparam logic [ByteWidth-1:0] ChLf    = 8'h0A;

  localparam logic [0:0] RegCapacity = 1'b0;

  // Packed so that status sits in the lowest bits.
  typedef struct packed {
    logic [CountWidth-1:0] bytes_held;
    logic                  byte_taken;
    logic                  simple_request;
    logic [1:0]            status;
  } hred_result_t;

  function automatic logic [3:0] scan_next(input logic [3:0] s,
                                           input logic [ByteWidth-1:0] c);
    logic lf;
    logic cr;
    logic blank;
    logic [3:0] n;
    lf    = (c == ChLf);
    cr    = (c == ChCr);
    blank = (c == ChSpace) || (c == ChTab) || cr;
    case (s)
      ScanFirstWord:  n = lf ? ScanBad : (blank ? ScanGap1 : ScanFirstWord);
      ScanGap1:       n = lf ? ScanBad : (blank ? ScanGap1 : ScanSecondWord);
      ScanGap2:       n = lf ? ScanDone : (blank ? ScanGap2 : ScanHeaderText);
      ScanSecondWord: n = lf ? ScanBad : (blank ? ScanGap2 : ScanSecondWord);
      ScanHeaderText,
      ScanTextCr:     n = cr ? ScanTextCr : (lf ? ScanLineStart : ScanHeaderText);
      ScanLineStart,
      ScanLineCr:     n = cr ? ScanLineCr : (lf ? ScanDone : ScanHeaderText);
      default:        n = s;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hred_cfg_regs.sv -----
// APB-style configuration register holding the buffer capacity.
// Depends on hred_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hred_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [1:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output logic      [hred_pkg::CountWidth-1:0]  capacity
);

  logic hit;

  assign hit    = (paddr[1:1] == 1'b0) && (paddr[0:0] == hred_pkg::RegCapacity);
  assign pready = 1'b1;
  assign prdata = hit ? {16'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= hred_pkg::CapacityReset;
    end else if (psel && penable && pwrite && pready && hit) begin
      capacity <= pwdata[hred_pkg::CountWidth-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hred_scan_core.sv -----
// Scan state, simple-request flag and byte count, with the one-byte
// step logic that produces a result word. Depends on hred_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hred_scan_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic [hred_pkg::ByteWidth-1:0]      data_byte,
  input  wire logic                                restart,
  input  wire logic [hred_pkg::CountWidth-1:0]     capacity,
  output hred_pkg::hred_result_t                   result
);

  logic [3:0]                      scan_state;
  logic                            simple_flag;
  logic [hred_pkg::CountWidth-1:0] byte_count;

  logic [3:0]                      scan_state_next;
  logic                            simple_flag_next;
  logic [hred_pkg::CountWidth-1:0] byte_count_next;

  logic [3:0]                      cur_state;
  logic                            cur_simple;
  logic [hred_pkg::CountWidth-1:0] cur_count;
  logic [3:0]                      stepped;

  always_comb begin
    cur_state  = restart ? hred_pkg::ScanFirstWord : scan_state;
    cur_simple = restart | simple_flag;
    cur_count  = restart ? '0 : byte_count;
    stepped    = hred_pkg::scan_next(cur_state, data_byte);

    scan_state_next  = cur_state;
    simple_flag_next = cur_simple;
    byte_count_next  = cur_count;
    result.status     = hred_pkg::StatIncomplete;
    result.byte_taken = 1'b0;

    if (cur_state == hred_pkg::ScanDone) begin
      result.status = hred_pkg::StatComplete;
    end else if (cur_state == hred_pkg::ScanBad) begin
      result.status = hred_pkg::StatMalformed;
    end else if (cur_state < hred_pkg::ScanDone && cur_count >= capacity) begin
      result.status = hred_pkg::StatOverflow;
    end else begin
      result.byte_taken = 1'b1;
      byte_count_next   = cur_count + {{(hred_pkg::CountWidth-1){1'b0}}, 1'b1};
      scan_state_next   = stepped;
      if (cur_state == hred_pkg::ScanGap2 && stepped == hred_pkg::ScanHeaderText) begin
        simple_flag_next = 1'b0;
      end
      if (stepped == hred_pkg::ScanDone) begin
        result.status = hred_pkg::StatComplete;
      end else if (stepped == hred_pkg::ScanBad) begin
        result.status = hred_pkg::StatMalformed;
      end
    end

    result.simple_request = simple_flag_next;
    result.bytes_held     = byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= hred_pkg::ScanFirstWord;
      simple_flag <= 1'b1;
      byte_count  <= '0;
    end else if (step) begin
      scan_state  <= scan_state_next;
      simple_flag <= simple_flag_next;
      byte_count  <= byte_count_next;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(scan_state) && $stable(byte_count) && $stable(simple_flag))
    else $error("scan state changed without a step");

  a_final_holds: assert property (@(posedge clk) disable iff (rst)
    step && !restart && (scan_state == hred_pkg::ScanDone ||
                         scan_state == hred_pkg::ScanBad)
    |=> $stable(byte_count) && $stable(scan_state))
    else $error("byte consumed after a final status");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    step && result.byte_taken |-> result.bytes_held <= capacity)
    else $error("byte count passed the buffer capacity");

  a_simple_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !restart && !simple_flag |=> !simple_flag)
    else $error("simple flag set again without a restart");

endmodule

`default_nettype wire

// ----- rtl/http_request_end_detector.sv -----
// Top level of the HTTP request end detector: input register, scan core,
// result register and configuration port. Depends on hred_pkg,
// hred_cfg_regs and hred_scan_core.
//
//   Port group   Direction  Payload
//   s_*          in         tdata: data_byte[7:0]; tuser: restart
//   m_*          out        tdata: status, simple_request, byte_taken, bytes_held
//   p* (APB)     in/out     buffer_capacity at byte address 0
//
// One word per cycle is sustained while the output is not stalled; the result
// word passes through the input register, then the result register.
// The scan step is a single pass from the input register into the result
// register, so the state is ready for the following word at once.
// Reset clears the scan state, count, valid flags and sets the capacity to 2048.
// A stalled output holds both registers; the input side stays ready while
// the input register is empty.
`timescale 1ns / 1ps
`default_nettype none

module http_request_end_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [1:0] status, [2] simple_request,
                                      // [3] byte_taken, [19:4] bytes_held, [23:20] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic                              in_valid;
  logic [hred_pkg::ByteWidth-1:0]    in_byte;
  logic                              in_restart;
  logic                              advance;
  logic                              step;
  logic [hred_pkg::CountWidth-1:0]   capacity;
  hred_pkg::hred_result_t            result;
  hred_pkg::hred_result_t            out_word;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {4'd0, out_word};

  hred_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  hred_scan_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .restart   (in_restart),
    .capacity  (capacity),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser;
    end
    if (step) begin
      out_word <= result;
    end
  end

endmodule

`default_nettype wire

// ----- verif/hred_checker.sv -----
// Result checker for the HTTP request end detector: watches the input, output
// and configuration channels, predicts each result word and compares it.
// Depends on hred_pkg for the scan, status and character codes.
`timescale 1ns / 1ps

module hred_checker
  import hred_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              drain_check,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  localparam logic [1:0] CapacityAddr = 2'(4 * RegCapacity);
  localparam int unsigned PrintLimit  = 40;

  logic [3:0]        scan_pos;
  logic              no_version;
  logic [15:0]       held;
  logic [15:0]       capacity;
  hred_result_t      expected_q[$];
  int unsigned       result_no;
  logic              drain_seen;

  task automatic report_mismatch(input string what);
    if (fail_count < PrintLimit) begin
      $display("%0t: result word %0d: %s", $realtime, result_no, what);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  function automatic hred_result_t predict_result(input logic [7:0] c,
                                                  input logic restart);
    hred_result_t r;
    logic lf;
    logic cr;
    logic blank;
    lf    = (c == ChLf);
    cr    = (c == ChCr);
    blank = (c == ChSpace) || (c == ChTab) || cr;
    r     = '0;
    r.status = StatIncomplete;
    if (restart) begin
      scan_pos   = ScanFirstWord;
      no_version = 1'b1;
      held       = '0;
    end
    if (scan_pos == ScanDone) begin
      r.status = StatComplete;
    end else if (scan_pos == ScanBad) begin
      r.status = StatMalformed;
    end else if (scan_pos < ScanDone && held >= capacity) begin
      r.status = StatOverflow;
    end else begin
      r.byte_taken = 1'b1;
      held = held + 16'd1;
      case (scan_pos)
        ScanFirstWord: begin
          if (lf) scan_pos = ScanBad;
          else if (blank) scan_pos = ScanGap1;
        end
        ScanGap1: begin
          if (lf) scan_pos = ScanBad;
          else if (!blank) scan_pos = ScanSecondWord;
        end
        ScanSecondWord: begin
          if (lf) scan_pos = ScanBad;
          else if (blank) scan_pos = ScanGap2;
        end
        ScanGap2: begin
          if (lf) begin
            scan_pos = ScanDone;
          end else if (!blank) begin
            scan_pos   = ScanHeaderText;
            no_version = 1'b0;
          end
        end
        ScanHeaderText, ScanTextCr: begin
          if (cr) scan_pos = ScanTextCr;
          else if (lf) scan_pos = ScanLineStart;
          else scan_pos = ScanHeaderText;
        end
        ScanLineStart, ScanLineCr: begin
          if (cr) scan_pos = ScanLineCr;
          else if (lf) scan_pos = ScanDone;
          else scan_pos = ScanHeaderText;
        end
        default: begin
        end
      endcase
      if (scan_pos == ScanDone) r.status = StatComplete;
      else if (scan_pos == ScanBad) r.status = StatMalformed;
    end
    r.simple_request = no_version;
    r.bytes_held     = held;
    return r;
  endfunction

  always @(posedge clk) begin
    hred_result_t got;
    hred_result_t want;
    if (rst) begin
      scan_pos   = ScanFirstWord;
      no_version = 1'b1;
      held       = '0;
      capacity   = CapacityReset;
      expected_q.delete();
      result_no  = 0;
      fail_count = 0;
      drain_seen = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CapacityAddr) begin
        capacity = pwdata[15:0];
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(predict_result(s_tdata, s_tuser));
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_q.pop_front();
          got  = hred_result_t'(m_tdata[19:0]);
          check_field("status", 16'(got.status), 16'(want.status));
          check_field("simple_request", 16'(got.simple_request),
                      16'(want.simple_request));
          check_field("byte_taken", 16'(got.byte_taken), 16'(want.byte_taken));
          check_field("bytes_held", got.bytes_held, want.bytes_held);
          check_field("padding", 16'(m_tdata[23:20]), 16'd0);
        end
        result_no++;
      end
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        if (expected_q.size() != 0) begin
          report_mismatch($sformatf("%0d result words never arrived", expected_q.size()));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the HTTP request end detector: clock, reset, request
// stimulus, output stalls and capacity writes, with the verdict at the end.
// Depends on hred_pkg, http_request_end_detector and hred_checker.
`timescale 1ns / 1ps

module tb_top;
  import hred_pkg::*;

  localparam int unsigned ItemTarget   = 1100;
  localparam int unsigned IdleLimit    = 1000;
  localparam logic [1:0]  CapacityAddr = 2'(4 * RegCapacity);

  typedef enum int unsigned {CharWord, CharText, CharBlank, CharAny} char_kind_t;
  typedef enum int unsigned {ReqFull, ReqSimple, ReqMalformed, ReqBroken, ReqNoise} req_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        drain_check;
  int unsigned fail_count;
  int unsigned pending;

  logic [8:0]  byte_q[$];
  int unsigned words_sent;
  bit          steady;

  always #5 clk = ~clk;

  http_request_end_detector u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hred_checker u_result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .drain_check (drain_check),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put(input logic restart, input logic [7:0] c);
    byte_q.push_back({restart, c});
  endfunction

  function automatic void add_run(input char_kind_t kind, input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      case (kind)
        CharWord: begin
          do c = 8'($urandom);
          while (c == ChSpace || c == ChTab || c == ChCr || c == ChLf);
        end
        CharText: begin
          do c = 8'($urandom);
          while (c == ChCr || c == ChLf);
        end
        CharBlank: begin
          case ($urandom_range(0, 2))
            0: c = ChSpace;
            1: c = ChTab;
            default: c = ChCr;
          endcase
        end
        default: c = 8'($urandom);
      endcase
      put(1'b0, c);
    end
  endfunction

  function automatic void add_line_end();
    repeat ($urandom_range(0, 2)) put(1'b0, ChCr);
    put(1'b0, ChLf);
  endfunction

  function automatic void build_request(input req_kind_t kind);
    int unsigned cut;
    case (kind)
      ReqNoise: begin
        repeat ($urandom_range(1, 16)) put($urandom_range(0, 7) == 0, 8'($urandom));
      end
      ReqMalformed: begin
        if ($urandom_range(0, 4) != 0) add_run(CharWord, $urandom_range(1, 6));
        if ($urandom_range(0, 1) == 0) begin
          add_run(CharBlank, $urandom_range(1, 3));
          add_run(CharWord, $urandom_range(0, 8));
        end
        put(1'b0, ChLf);
      end
      ReqSimple: begin
        add_run(CharWord, $urandom_range(1, 6));
        add_run(CharBlank, $urandom_range(1, 3));
        add_run(CharWord, $urandom_range(1, 10));
        add_run(CharBlank, $urandom_range(1, 2));
        put(1'b0, ChLf);
      end
      default: begin
        add_run(CharWord, $urandom_range(1, 6));
        add_run(CharBlank, $urandom_range(1, 3));
        add_run(CharWord, $urandom_range(1, 10));
        add_run(CharBlank, $urandom_range(1, 2));
        add_run(CharWord, 1);
        add_run(CharText, $urandom_range(0, 7));
        add_line_end();
        repeat ($urandom_range(0, 4)) begin
          add_run(CharWord, 1);
          add_run(CharText, $urandom_range(0, 15));
          add_line_end();
        end
        add_line_end();
      end
    endcase
    if (kind == ReqBroken) begin
      cut = $urandom_range(1, byte_q.size() - 1);
      while (byte_q.size() > cut) void'(byte_q.pop_back());
    end
    if (kind != ReqNoise && $urandom_range(0, 9) != 0) byte_q[0][8] = 1'b1;
    if ((kind == ReqFull || kind == ReqSimple) && $urandom_range(0, 3) == 0) begin
      add_run(CharAny, $urandom_range(1, 3));
    end
  endfunction

  function automatic req_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ReqFull;
    if (r < 60) return ReqSimple;
    if (r < 75) return ReqMalformed;
    if (r < 87) return ReqBroken;
    return ReqNoise;
  endfunction

  task automatic send_word(input logic restart, input logic [7:0] data);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= restart;
    s_tdata  <= data;
    do @(posedge clk);
    while (!s_tready);
    words_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_queued();
    logic [8:0] w;
    while (byte_q.size() != 0) begin
      w = byte_q.pop_front();
      send_word(w[8], w[7:0]);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapacityAddr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : sink_pacing
    int unsigned r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (r < 68) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(80, 200)) @(posedge clk);
      end else if (r < 95) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(15, 60)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] cap;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    drain_check <= 1'b0;
    steady      = 1'b1;
    words_sent  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Line feed as the very first byte, then a word held back by the final status.
    put(1'b1, ChLf);
    put(1'b0, 8'h00);
    // Simple request built from the extreme byte values.
    put(1'b1, 8'hFF);
    put(1'b0, ChSpace);
    put(1'b0, 8'h00);
    put(1'b0, ChTab);
    put(1'b0, ChLf);
    put(1'b0, 8'h78);
    // Full request with carriage returns in the request line and the empty line.
    put(1'b1, 8'h47);
    put(1'b0, ChCr);
    put(1'b0, 8'h2F);
    put(1'b0, ChSpace);
    put(1'b0, 8'h48);
    put(1'b0, ChLf);
    put(1'b0, ChCr);
    put(1'b0, ChLf);
    // Unfinished request line left in the middle of its second word.
    put(1'b1, 8'h61);
    put(1'b0, ChSpace);
    put(1'b0, 8'h62);
    send_queued();
    wait_idle();

    // Capacity lowered below the count already held.
    write_capacity(16'd2);
    put(1'b0, 8'h63);
    send_queued();
    wait_idle();

    write_capacity(16'd1);
    put(1'b1, 8'h78);
    put(1'b0, 8'h79);
    send_queued();
    wait_idle();

    // The line feed that completes the simple request lands in the last free slot.
    write_capacity(16'd5);
    put(1'b1, 8'h61);
    put(1'b0, ChSpace);
    put(1'b0, 8'h62);
    put(1'b0, ChSpace);
    put(1'b0, ChLf);
    send_queued();

    while (words_sent < ItemTarget) begin
      wait_idle();
      case ($urandom_range(0, 6))
        0: cap = 16'd1;
        1: cap = 16'hFFFF;
        2: cap = CapacityReset;
        3: cap = 16'($urandom_range(2, 12));
        4: cap = 16'($urandom_range(13, 60));
        5: cap = 16'($urandom_range(1, 65535));
        default: cap = 16'($urandom_range(20, 120));
      endcase
      write_capacity(cap);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        build_request(pick_kind());
        send_queued();
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    drain_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
